// ----- src/vosc_pkg.sv -----
// Shared constants for the voxel overhang support check unit.
// Register map, field widths, counter limits and the divide-by-three constants.
// No dependencies.
package vosc_pkg;

    // Default grid limits
    localparam int unsigned DEF_MAX_X = 64;
    localparam int unsigned DEF_MAX_Y = 64;
    localparam int unsigned DEF_MAX_Z = 64;

    // Field widths
    localparam int unsigned DENS_W  = 16;
    localparam int unsigned SIZE_W  = 7;
    localparam int unsigned COUNT_W = 19;

    // Configuration port
    localparam int unsigned APB_AW    = 4;
    localparam int unsigned APB_DW    = 32;
    localparam int unsigned REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_X    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Y    = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Z    = 2'd3;

    localparam logic [DENS_W-1:0] THRESHOLD_RST = 16'd32768;
    localparam logic [SIZE_W-1:0] SIZE_RST      = 7'd64;

    // Counters saturate at all ones
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Support-free test: unsupported * RATIO_LIMIT must not exceed solid
    localparam int unsigned RATIO_LIMIT = 1000;
    localparam int unsigned RATIO_W     = COUNT_W + $clog2(RATIO_LIMIT);

    // Rows of a layer are spread over three memories by row mod 3, so the
    // three rows under a voxel always sit in different memories
    localparam int unsigned ROW_MEMS  = 3;
    localparam logic [1:0]  LAST_SLOT = 2'd2;

    // Row / 3 as (row * 683) >> 11, exact for rows below 2048
    localparam int unsigned DIV3_IN_W   = 11;
    localparam int unsigned DIV3_MUL    = 683;
    localparam int unsigned DIV3_SHIFT  = 11;
    localparam int unsigned DIV3_PROD_W = 22;
    localparam int unsigned DIV3_Q_W    = 10;

    // Output beat layout
    localparam int unsigned TDATA_W   = 48;
    localparam int unsigned TDATA_PAD = TDATA_W - (2 * COUNT_W + 3);

endpackage

// ----- src/voxel_overhang_support_check_unit.sv -----
// Voxel overhang support check: streaming solid test, 3x3 support lookup in
// the previous layer's solid map, saturating counts and the end-of-grid verdict.
// Depends on vosc_pkg.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-----------------------------------------
//  cfg     | in  | psel/penable      | paddr, pwdata, prdata (4 registers)
//  s       | in  | s_tvalid/s_tready | s_tdata: density
//  m       | out | m_tvalid/m_tready | m_tdata: result fields, m_tlast: grid_done
//
//  One beat per clock while the output is not stalled; each result passes
//  the input/read register, then the result register.
//  The solid map lives in three row memories (row mod 3), so the three rows
//  under a voxel come out of one registered read per memory.
//  A stalled result holds the stage behind it; s_tready drops only when both
//  stages are full and m_tready is low.
//  Reset clears position, counters and valid flags and loads register defaults;
//  the map needs no clearing pass, since a layer is only looked up after it is written.
module voxel_overhang_support_check_unit #(
    parameter int unsigned MAX_X = vosc_pkg::DEF_MAX_X,
    parameter int unsigned MAX_Y = vosc_pkg::DEF_MAX_Y,
    parameter int unsigned MAX_Z = vosc_pkg::DEF_MAX_Z
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vosc_pkg::APB_AW-1:0]   paddr,
    input  logic [vosc_pkg::APB_DW-1:0]   pwdata,
    output logic [vosc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    // voxel input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vosc_pkg::DENS_W-1:0]   s_tdata,   // [15:0] density
    // result output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] is_solid, [1] is_unsupported, [20:2] solid_total,
    // [39:21] unsupported_total, [40] support_free, [47:41] zero
    output logic [vosc_pkg::TDATA_W-1:0]  m_tdata,
    output logic                          m_tlast    // grid_done
);
    import vosc_pkg::*;

    localparam int unsigned XW    = $clog2(MAX_X);
    localparam int unsigned YW    = $clog2(MAX_Y);
    localparam int unsigned ZW    = $clog2(MAX_Z);
    localparam int unsigned EXW   = XW + 1;
    localparam int unsigned EYW   = YW + 1;
    localparam int unsigned EZW   = ZW + 1;
    localparam int unsigned CXW   = (EXW > SIZE_W) ? EXW : SIZE_W;
    localparam int unsigned CYW   = (EYW > SIZE_W) ? EYW : SIZE_W;
    localparam int unsigned CZW   = (EZW > SIZE_W) ? EZW : SIZE_W;
    localparam int unsigned MAX_Q = (MAX_Y + 2) / 3;
    localparam int unsigned QW    = (MAX_Q > 1) ? $clog2(MAX_Q) : 1;

    typedef struct packed {
        logic          solid;
        logic          done;
        logic          base_passed;
        logic [1:0]    slot;
        logic [XW-1:0] x;
        logic          lft_ok;
        logic          rgt_ok;
        logic          top_ok;
        logic          bot_ok;
    } s1_t;

    // configuration registers
    logic [DENS_W-1:0] thr_reg;
    logic [SIZE_W-1:0] size_x_reg;
    logic [SIZE_W-1:0] size_y_reg;
    logic [SIZE_W-1:0] size_z_reg;
    logic              cfg_wr;

    // front-end state
    logic [XW-1:0] pos_x_reg;
    logic [YW-1:0] pos_y_reg;
    logic [ZW-1:0] pos_z_reg;
    logic          bank_reg;
    logic          lhs_reg;
    logic          blp_reg;

    logic [CXW-1:0] size_x_ext;
    logic [CYW-1:0] size_y_ext;
    logic [CZW-1:0] size_z_ext;
    logic [EXW-1:0] sx_eff;
    logic [EYW-1:0] sy_eff;
    logic [EZW-1:0] sz_eff;
    logic           row_end;
    logic           plane_end;
    logic           grid_end;
    logic [XW-1:0]  x_cl;
    logic [YW-1:0]  y_cl;
    logic           solid_in;
    logic           lhs_new;

    logic [DIV3_PROD_W-1:0] y_prod;
    logic [DIV3_Q_W-1:0]    q_full;
    logic [DIV3_IN_W-1:0]   y_rem;
    logic [QW-1:0]          y_q;
    logic [1:0]             y_m;
    logic [1:0]             m_top;
    logic [QW-1:0]          q_up;
    logic [QW-1:0]          q_dn;
    logic [QW-1:0]          rd_addr [ROW_MEMS];
    logic [MAX_X-1:0]       rd_row  [ROW_MEMS];

    // pipeline control
    logic in_acc;
    logic s1_vld_reg;
    logic s1_adv;
    logic out_vld_reg;
    s1_t  s1_next;
    s1_t  s1_reg;

    // result stage
    logic [MAX_X-1:0]   top_w;
    logic [MAX_X-1:0]   mid_w;
    logic [MAX_X-1:0]   bot_w;
    logic               any_below;
    logic               unsup;
    logic [COUNT_W-1:0] sc_reg;
    logic [COUNT_W-1:0] uc_reg;
    logic [COUNT_W-1:0] sc_next;
    logic [COUNT_W-1:0] uc_next;
    logic [RATIO_W-1:0] uc_scaled;
    logic               sf;

    logic               out_solid_reg;
    logic               out_unsup_reg;
    logic               out_done_reg;
    logic               out_sf_reg;
    logic [COUNT_W-1:0] out_sc_reg;
    logic [COUNT_W-1:0] out_uc_reg;

    function automatic logic row_hit(input logic [MAX_X-1:0] w, input logic [XW-1:0] x,
                                     input logic lft, input logic rgt);
        logic [XW-1:0] xl;
        logic [XW-1:0] xr;
        xl = x - 1'b1;
        xr = x + 1'b1;
        return w[x] | (lft & w[xl]) | (rgt & w[xr]);
    endfunction

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Write registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= THRESHOLD_RST;
            size_x_reg <= SIZE_RST;
            size_y_reg <= SIZE_RST;
            size_z_reg <= SIZE_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[REG_IDX_W+1:2])
                REG_THRESHOLD: thr_reg    <= pwdata[DENS_W-1:0];
                REG_SIZE_X:    size_x_reg <= pwdata[SIZE_W-1:0];
                REG_SIZE_Y:    size_y_reg <= pwdata[SIZE_W-1:0];
                REG_SIZE_Z:    size_z_reg <= pwdata[SIZE_W-1:0];
                default:       ;
            endcase
        end
    end

    // Read back registers
    always_comb
    begin
        case (paddr[REG_IDX_W+1:2])
            REG_THRESHOLD: prdata = APB_DW'(thr_reg);
            REG_SIZE_X:    prdata = APB_DW'(size_x_reg);
            REG_SIZE_Y:    prdata = APB_DW'(size_y_reg);
            REG_SIZE_Z:    prdata = APB_DW'(size_z_reg);
            default:       prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Input side: position, clamping, map addressing
    // ---------------------------------------------------------------
    assign s1_adv   = s1_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !s1_vld_reg || s1_adv;
    assign in_acc   = s_tvalid && s_tready;

    // Clamp grid sizes: zero acts as one, above the limit acts as the limit
    always_comb
    begin
        size_x_ext = CXW'(size_x_reg);
        size_y_ext = CYW'(size_y_reg);
        size_z_ext = CZW'(size_z_reg);
        if (size_x_reg == '0)
            sx_eff = EXW'(1);
        else if (size_x_ext > CXW'(MAX_X))
            sx_eff = EXW'(MAX_X);
        else
            sx_eff = EXW'(size_x_ext);
        if (size_y_reg == '0)
            sy_eff = EYW'(1);
        else if (size_y_ext > CYW'(MAX_Y))
            sy_eff = EYW'(MAX_Y);
        else
            sy_eff = EYW'(size_y_ext);
        if (size_z_reg == '0)
            sz_eff = EZW'(1);
        else if (size_z_ext > CZW'(MAX_Z))
            sz_eff = EZW'(MAX_Z);
        else
            sz_eff = EZW'(size_z_ext);
    end

    // Decode the position of the incoming beat
    always_comb
    begin
        row_end   = (EXW'(pos_x_reg) + EXW'(1)) >= sx_eff;
        plane_end = row_end && ((EYW'(pos_y_reg) + EYW'(1)) >= sy_eff);
        grid_end  = plane_end && ((EZW'(pos_z_reg) + EZW'(1)) >= sz_eff);
        x_cl      = (EXW'(pos_x_reg) < sx_eff) ? pos_x_reg : XW'(sx_eff - EXW'(1));
        y_cl      = (EYW'(pos_y_reg) < sy_eff) ? pos_y_reg : YW'(sy_eff - EYW'(1));
        solid_in  = s_tdata >= thr_reg;
        lhs_new   = lhs_reg || solid_in;
    end

    // Split the row into memory slot (row mod 3) and entry (row / 3)
    always_comb
    begin
        y_prod = DIV3_PROD_W'(y_cl) * DIV3_PROD_W'(DIV3_MUL);
        q_full = y_prod[DIV3_SHIFT +: DIV3_Q_W];
        y_rem  = DIV3_IN_W'(y_cl) - DIV3_IN_W'(DIV3_IN_W'(q_full) * DIV3_IN_W'(ROW_MEMS));
        y_m    = y_rem[1:0];
        y_q    = q_full[QW-1:0];
        m_top  = (y_m == '0) ? LAST_SLOT : y_m - 2'd1;
        q_up   = (y_q == '0) ? y_q : y_q - 1'b1;
        q_dn   = (y_q == QW'(MAX_Q - 1)) ? y_q : y_q + 1'b1;
    end

    // Address the rows above, at and below this row in the previous layer
    always_comb
    begin
        for (int k = 0; k < ROW_MEMS; k++)
        begin
            if (y_m == 2'(k))
                rd_addr[k] = y_q;
            else if (m_top == 2'(k))
                rd_addr[k] = (y_m == '0) ? q_up : y_q;
            else
                rd_addr[k] = (y_m == LAST_SLOT) ? q_dn : y_q;
        end
    end

    // Row memories: write this voxel's solid bit, read the previous layer
    for (genvar k = 0; k < ROW_MEMS; k++)
    begin : g_row_mem
        logic [MAX_X-1:0] mem [2][MAX_Q];

        always_ff @(posedge clk)
        begin
            if (in_acc)
            begin
                if (y_m == 2'(k))
                    mem[bank_reg][y_q][x_cl] <= solid_in;
                rd_row[k] <= mem[~bank_reg][rd_addr[k]];
            end
        end
    end

    // Advance position, bank and layer flags on each input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
            bank_reg  <= 1'b0;
            lhs_reg   <= 1'b0;
            blp_reg   <= 1'b0;
        end
        else if (in_acc)
        begin
            if (grid_end)
            begin
                pos_x_reg <= '0;
                pos_y_reg <= '0;
                pos_z_reg <= '0;
                bank_reg  <= 1'b0;
                lhs_reg   <= 1'b0;
                blp_reg   <= 1'b0;
            end
            else if (plane_end)
            begin
                pos_x_reg <= '0;
                pos_y_reg <= '0;
                pos_z_reg <= pos_z_reg + 1'b1;
                bank_reg  <= ~bank_reg;
                lhs_reg   <= 1'b0;
                blp_reg   <= blp_reg || lhs_new;
            end
            else if (row_end)
            begin
                pos_x_reg <= '0;
                pos_y_reg <= pos_y_reg + 1'b1;
                lhs_reg   <= lhs_new;
            end
            else
            begin
                pos_x_reg <= pos_x_reg + 1'b1;
                lhs_reg   <= lhs_new;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage one register
    // ---------------------------------------------------------------
    always_comb
    begin
        s1_next.solid       = solid_in;
        s1_next.done        = grid_end;
        s1_next.base_passed = blp_reg;
        s1_next.slot        = y_m;
        s1_next.x           = x_cl;
        s1_next.lft_ok      = x_cl != '0;
        s1_next.rgt_ok      = (EXW'(x_cl) + EXW'(1)) < sx_eff;
        s1_next.top_ok      = y_cl != '0;
        s1_next.bot_ok      = (EYW'(y_cl) + EYW'(1)) < sy_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (in_acc)
            s1_vld_reg <= 1'b1;
        else if (s1_adv)
            s1_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            s1_reg <= s1_next;
    end

    // ---------------------------------------------------------------
    // Result stage: support lookup, counters, verdict
    // ---------------------------------------------------------------
    // Route the three memory words to their row roles
    always_comb
    begin
        case (s1_reg.slot)
            2'd0:
            begin
                top_w = rd_row[2];
                mid_w = rd_row[0];
                bot_w = rd_row[1];
            end
            2'd1:
            begin
                top_w = rd_row[0];
                mid_w = rd_row[1];
                bot_w = rd_row[2];
            end
            2'd2:
            begin
                top_w = rd_row[1];
                mid_w = rd_row[2];
                bot_w = rd_row[0];
            end
            default:
            begin
                top_w = '0;
                mid_w = '0;
                bot_w = '0;
            end
        endcase
    end

    always_comb
    begin
        any_below = (s1_reg.top_ok && row_hit(top_w, s1_reg.x, s1_reg.lft_ok, s1_reg.rgt_ok))
                 || row_hit(mid_w, s1_reg.x, s1_reg.lft_ok, s1_reg.rgt_ok)
                 || (s1_reg.bot_ok && row_hit(bot_w, s1_reg.x, s1_reg.lft_ok, s1_reg.rgt_ok));
        unsup     = s1_reg.solid && s1_reg.base_passed && !any_below;
        sc_next   = (s1_reg.solid && sc_reg != COUNT_MAX) ? sc_reg + 1'b1 : sc_reg;
        uc_next   = (unsup && uc_reg != COUNT_MAX) ? uc_reg + 1'b1 : uc_reg;
        uc_scaled = RATIO_W'(uc_next) * RATIO_W'(RATIO_LIMIT);
        sf        = s1_reg.done && !(uc_scaled > RATIO_W'(sc_next));
    end

    // Hold counters; drop them to zero after the last voxel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg <= '0;
            uc_reg <= '0;
        end
        else if (s1_adv)
        begin
            sc_reg <= s1_reg.done ? '0 : sc_next;
            uc_reg <= s1_reg.done ? '0 : uc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (s1_adv)
            out_vld_reg <= 1'b1;
        else if (m_tready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_solid_reg <= s1_reg.solid;
            out_unsup_reg <= unsup;
            out_done_reg  <= s1_reg.done;
            out_sf_reg    <= sf;
            out_sc_reg    <= sc_next;
            out_uc_reg    <= uc_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_done_reg;
    assign m_tdata  = {{TDATA_PAD{1'b0}}, out_sf_reg, out_uc_reg, out_sc_reg,
                       out_unsup_reg, out_solid_reg};

`ifndef SYNTH
    a_counts_order: assert property (@(posedge clk) disable iff (!rst_n)
        uc_reg <= sc_reg)
        else $error("unsupported count above solid count");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && out_vld_reg && !m_tready) |-> !s_tready)
        else $error("input taken while both stages are full");

    a_grid_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && grid_end) |=> (!bank_reg && !blp_reg && !lhs_reg
                                  && pos_x_reg == '0 && pos_y_reg == '0 && pos_z_reg == '0))
        else $error("grid state not restarted after last voxel");

    a_unsup_solid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_unsup_reg) |-> out_solid_reg)
        else $error("unsupported voxel that is not solid");

    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_done_reg) |-> !out_sf_reg)
        else $error("support_free set before the last voxel");
`endif

endmodule

// ----- sim/voxel_overhang_support_check_unit_tb.sv -----
`timescale 1ns / 100ps
// Testbench for voxel_overhang_support_check_unit: a directed stimulus table, then random
// grids; each beat is checked against its table entry or the in-bench support predictor.
// Depends on vosc_pkg and the unit itself.
module voxel_overhang_support_check_unit_tb;
    import vosc_pkg::*;

    localparam int unsigned GRID_X          = DEF_MAX_X;
    localparam int unsigned GRID_Y          = DEF_MAX_Y;
    localparam int unsigned GRID_Z          = DEF_MAX_Z;
    localparam int unsigned PLANE_SZ        = GRID_X * GRID_Y;
    localparam int unsigned RANDOM_ITEMS    = 950;
    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned HOLD_OFF_ITEMS  = 8;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned MAX_REPORTS     = 10;
    localparam logic [DENS_W-1:0] DENS_MAX  = '1;

    typedef struct packed {
        logic               solid;
        logic               unsup;
        logic               done;
        logic [COUNT_W-1:0] solid_total;
        logic [COUNT_W-1:0] unsup_total;
        logic               support_free;
    } voxel_result_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_VOXEL, ROW_VOXEL_TYPED} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [REG_IDX_W-1:0] reg_idx;
        logic [APB_DW-1:0]    value;
        logic [DENS_W-1:0]    dens;
        voxel_result_t        want;
    } stim_row_t;

    localparam voxel_result_t NO_WANT = '0;

    // Directed rows: reset config, a mid-grid shrink, empty grid, threshold
    // extremes, then a small grid with an empty first layer and a floating voxel
    localparam int unsigned DIR_ROWS = 25;
    localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
        '{ROW_VOXEL_TYPED, REG_THRESHOLD, 32'd0, 16'd0,
          '{1'b0, 1'b0, 1'b0, 19'd0, 19'd0, 1'b0}},
        '{ROW_VOXEL_TYPED, REG_THRESHOLD, 32'd0, 16'd65535,
          '{1'b1, 1'b0, 1'b0, 19'd1, 19'd0, 1'b0}},
        '{ROW_VOXEL_TYPED, REG_THRESHOLD, 32'd0, 16'd32768,
          '{1'b1, 1'b0, 1'b0, 19'd2, 19'd0, 1'b0}},
        '{ROW_VOXEL_TYPED, REG_THRESHOLD, 32'd0, 16'd32767,
          '{1'b0, 1'b0, 1'b0, 19'd2, 19'd0, 1'b0}},
        '{ROW_CFG, REG_SIZE_Z, 32'd1, 16'd0, NO_WANT},
        '{ROW_CFG, REG_SIZE_Y, 32'd1, 16'd0, NO_WANT},
        '{ROW_CFG, REG_SIZE_X, 32'd0, 16'd0, NO_WANT},
        '{ROW_VOXEL_TYPED, REG_THRESHOLD, 32'd0, 16'd65535,
          '{1'b1, 1'b0, 1'b1, 19'd3, 19'd0, 1'b1}},
        '{ROW_CFG, REG_THRESHOLD, 32'd65535, 16'd0, NO_WANT},
        '{ROW_VOXEL_TYPED, REG_THRESHOLD, 32'd0, 16'd65534,
          '{1'b0, 1'b0, 1'b1, 19'd0, 19'd0, 1'b1}},
        '{ROW_VOXEL_TYPED, REG_THRESHOLD, 32'd0, 16'd65535,
          '{1'b1, 1'b0, 1'b1, 19'd1, 19'd0, 1'b1}},
        '{ROW_CFG, REG_THRESHOLD, 32'd0, 16'd0, NO_WANT},
        '{ROW_VOXEL_TYPED, REG_THRESHOLD, 32'd0, 16'd0,
          '{1'b1, 1'b0, 1'b1, 19'd1, 19'd0, 1'b1}},
        '{ROW_CFG, REG_THRESHOLD, 32'd32768, 16'd0, NO_WANT},
        '{ROW_CFG, REG_SIZE_X, 32'd3, 16'd0, NO_WANT},
        '{ROW_CFG, REG_SIZE_Z, 32'd3, 16'd0, NO_WANT},
        '{ROW_VOXEL, REG_THRESHOLD, 32'd0, 16'd0, NO_WANT},
        '{ROW_VOXEL, REG_THRESHOLD, 32'd0, 16'd1000, NO_WANT},
        '{ROW_VOXEL, REG_THRESHOLD, 32'd0, 16'd32767, NO_WANT},
        '{ROW_VOXEL, REG_THRESHOLD, 32'd0, 16'd40000, NO_WANT},
        '{ROW_VOXEL, REG_THRESHOLD, 32'd0, 16'd0, NO_WANT},
        '{ROW_VOXEL, REG_THRESHOLD, 32'd0, 16'd0, NO_WANT},
        '{ROW_VOXEL, REG_THRESHOLD, 32'd0, 16'd0, NO_WANT},
        '{ROW_VOXEL, REG_THRESHOLD, 32'd0, 16'd0, NO_WANT},
        '{ROW_VOXEL_TYPED, REG_THRESHOLD, 32'd0, 16'd65535,
          '{1'b1, 1'b1, 1'b1, 19'd2, 19'd1, 1'b0}}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                s_tvalid;
    logic                s_tready;
    logic [DENS_W-1:0]   s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tlast;

    // Predictor copy of registers and grid state
    logic [DENS_W-1:0]   sh_threshold;
    logic [SIZE_W-1:0]   sh_size_x;
    logic [SIZE_W-1:0]   sh_size_y;
    logic [SIZE_W-1:0]   sh_size_z;
    bit                  solid_map [2][PLANE_SZ];
    bit                  map_bank;
    int unsigned         at_x;
    int unsigned         at_y;
    int unsigned         at_z;
    bit                  base_passed;
    bit                  layer_solid;
    logic [COUNT_W-1:0]  n_solid;
    logic [COUNT_W-1:0]  n_unsup;

    voxel_result_t       pending_results [$];
    int unsigned         n_errors = 0;
    int unsigned         idle_cycles = 0;
    bit                  quiet = 1'b0;
    bit                  hold_off_req = 1'b0;

    voxel_overhang_support_check_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Gap length for either side: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        if (r < 98)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Size 0 acts as 1, oversize clamps to the grid limit
    function automatic int unsigned eff_dim(input logic [SIZE_W-1:0] v, input int unsigned limit);
        if (v == 0)
            return 1;
        if (32'(v) > limit)
            return limit;
        return 32'(v);
    endfunction

    function automatic void clear_grid();
        map_bank    = 1'b0;
        at_x        = 0;
        at_y        = 0;
        at_z        = 0;
        base_passed = 1'b0;
        layer_solid = 1'b0;
        n_solid     = '0;
        n_unsup     = '0;
    endfunction

    // Any solid voxel in the 3x3 block of the previous layer; outside is empty
    function automatic bit layer_below_solid(input int unsigned x, input int unsigned y,
                                             input int unsigned sx, input int unsigned sy);
        bit prev;
        int nx;
        int ny;
        prev = ~map_bank;
        for (int dy = -1; dy <= 1; dy++)
        begin
            for (int dx = -1; dx <= 1; dx++)
            begin
                nx = int'(x) + dx;
                ny = int'(y) + dy;
                if (nx < 0 || ny < 0 || nx >= int'(sx) || ny >= int'(sy))
                    continue;
                if (solid_map[prev][ny * GRID_X + nx])
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Score one voxel and advance the raster position
    function automatic voxel_result_t score_voxel(input logic [DENS_W-1:0] dens);
        int unsigned   sx;
        int unsigned   sy;
        int unsigned   sz;
        int unsigned   x;
        int unsigned   y;
        bit            row_end;
        bit            plane_end;
        voxel_result_t r;
        sx = eff_dim(sh_size_x, GRID_X);
        sy = eff_dim(sh_size_y, GRID_Y);
        sz = eff_dim(sh_size_z, GRID_Z);
        r = '0;
        r.solid   = (dens >= sh_threshold);
        row_end   = (at_x + 1 >= sx);
        plane_end = row_end && (at_y + 1 >= sy);
        r.done    = plane_end && (at_z + 1 >= sz);
        x = (at_x < sx) ? at_x : sx - 1;
        y = (at_y < sy) ? at_y : sy - 1;
        if (r.solid)
        begin
            layer_solid = 1'b1;
            if (n_solid != COUNT_MAX)
                n_solid = n_solid + 1'b1;
            if (base_passed && !layer_below_solid(x, y, sx, sy))
            begin
                r.unsup = 1'b1;
                if (n_unsup != COUNT_MAX)
                    n_unsup = n_unsup + 1'b1;
            end
        end
        solid_map[map_bank][y * GRID_X + x] = r.solid;
        r.solid_total = n_solid;
        r.unsup_total = n_unsup;
        if (r.done)
            r.support_free = !(64'(n_unsup) * RATIO_LIMIT > 64'(n_solid));
        if (r.done)
            clear_grid();
        else if (plane_end)
        begin
            if (layer_solid)
                base_passed = 1'b1;
            layer_solid = 1'b0;
            map_bank    = ~map_bank;
            at_x = 0;
            at_y = 0;
            at_z = at_z + 1;
        end
        else if (row_end)
        begin
            at_x = 0;
            at_y = at_y + 1;
        end
        else
            at_x = at_x + 1;
        return r;
    endfunction

    // Density on the chosen side of the threshold
    function automatic logic [DENS_W-1:0] pick_density(input bit solid);
        if (solid)
            return DENS_W'($urandom_range(DENS_MAX, sh_threshold));
        if (sh_threshold == 0)
            return DENS_W'($urandom_range(DENS_MAX, 0));
        return DENS_W'($urandom_range(sh_threshold - 1, 0));
    endfunction

    // Register write: setup cycle, then access cycle
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_THRESHOLD: sh_threshold = value[DENS_W-1:0];
            REG_SIZE_X:    sh_size_x    = value[SIZE_W-1:0];
            REG_SIZE_Y:    sh_size_y    = value[SIZE_W-1:0];
            REG_SIZE_Z:    sh_size_z    = value[SIZE_W-1:0];
            default:       ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drop valid and wait until every queued result has come back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Offer one voxel beat after a random gap; queue its expected result
    task automatic send_voxel(input logic [DENS_W-1:0] dens, input bit use_want,
                              input voxel_result_t want);
        int unsigned   gap;
        voxel_result_t predicted;
        gap = pick_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= dens;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = score_voxel(dens);
        pending_results.insert(pending_results.size(), use_want ? want : predicted);
    endtask

    // Main stimulus
    initial
    begin
        int unsigned       random_sent;
        int unsigned       phase_idx;
        int unsigned       shape;
        int unsigned       pick;
        int unsigned       grids;
        int unsigned       ex;
        int unsigned       ey;
        int unsigned       ez;
        int unsigned       fill;
        bit                held_off;
        logic [SIZE_W-1:0] vx;
        logic [SIZE_W-1:0] vy;
        logic [SIZE_W-1:0] vz;
        logic [SIZE_W-1:0] big;
        logic [DENS_W-1:0] th;
        logic [DENS_W-1:0] d;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        rst_n    = 1'b0;
        sh_threshold = THRESHOLD_RST;
        sh_size_x    = SIZE_RST;
        sh_size_y    = SIZE_RST;
        sh_size_z    = SIZE_RST;
        clear_grid();
        random_sent = 0;
        phase_idx   = 0;
        held_off    = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (DIR_TABLE[i].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(DIR_TABLE[i].reg_idx, DIR_TABLE[i].value);
            end
            else
                send_voxel(DIR_TABLE[i].dens, DIR_TABLE[i].kind == ROW_VOXEL_TYPED,
                           DIR_TABLE[i].want);
        end

        // Random phases, each a new setting followed by whole grids until the item limit
        while (random_sent < RANDOM_ITEMS)
        begin
            drain_results();
            quiet = ($urandom_range(3) == 0);
            shape = $urandom_range(9);
            big   = $urandom_range(1) ? 7'd64 : 7'd127;
            case (shape)
                0:
                begin
                    vx = big;
                    vy = 1;
                    vz = SIZE_W'($urandom_range(2, 1));
                end
                1:
                begin
                    vx = 1;
                    vy = big;
                    vz = SIZE_W'($urandom_range(2, 1));
                end
                2:
                begin
                    vx = 1;
                    vy = 1;
                    vz = big;
                end
                3:
                begin
                    vx = SIZE_W'($urandom_range(1, 0));
                    vy = SIZE_W'($urandom_range(1, 0));
                    vz = SIZE_W'($urandom_range(3, 0));
                end
                default:
                begin
                    vx = SIZE_W'($urandom_range(6, 1));
                    vy = SIZE_W'($urandom_range(6, 1));
                    vz = SIZE_W'($urandom_range(5, 1));
                end
            endcase
            pick = $urandom_range(9);
            if (pick == 0)
                th = '0;
            else if (pick == 1)
                th = DENS_MAX;
            else if (pick == 2)
                th = 16'd1;
            else
                th = DENS_W'($urandom());
            // Junk above each field must be ignored
            write_reg(REG_THRESHOLD, ($urandom() << DENS_W) | th);
            write_reg(REG_SIZE_X, ($urandom() << SIZE_W) | vx);
            write_reg(REG_SIZE_Y, ($urandom() << SIZE_W) | vy);
            write_reg(REG_SIZE_Z, ($urandom() << SIZE_W) | vz);
            grids = (shape <= 2) ? 1 : $urandom_range(3, 1);
            ex = eff_dim(sh_size_x, GRID_X);
            ey = eff_dim(sh_size_y, GRID_Y);
            ez = eff_dim(sh_size_z, GRID_Z);
            // Hold the receiver off once, in a phase long enough to fill the unit
            if (!held_off && phase_idx >= 2 && grids * ex * ey * ez >= HOLD_OFF_ITEMS
                && RANDOM_ITEMS - random_sent >= HOLD_OFF_ITEMS)
            begin
                hold_off_req = 1'b1;
                held_off     = 1'b1;
            end
            for (int g = 0; g < grids; g++)
            begin
                for (int z = 0; z < ez; z++)
                begin
                    // Per layer: empty, dense, full or patchy
                    pick = $urandom_range(9);
                    if (pick < 2)
                        fill = 0;
                    else if (pick < 5)
                        fill = 90;
                    else if (pick < 6)
                        fill = 100;
                    else
                        fill = $urandom_range(60, 5);
                    for (int n = 0; n < ex * ey && random_sent < RANDOM_ITEMS; n++)
                    begin
                        if ($urandom_range(99) < 8)
                            d = DENS_W'($urandom());
                        else
                            d = pick_density($urandom_range(99) < fill);
                        send_voxel(d, 1'b0, NO_WANT);
                        random_sent++;
                    end
                end
            end
            phase_idx++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0 && pending_results.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Result receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int unsigned stall;
        stall    = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        voxel_result_t want;
        voxel_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.solid        = m_tdata[0];
            got.unsup        = m_tdata[1];
            got.done         = m_tlast;
            got.solid_total  = m_tdata[2 +: COUNT_W];
            got.unsup_total  = m_tdata[2 + COUNT_W +: COUNT_W];
            got.support_free = m_tdata[2 + 2 * COUNT_W];
            if (pending_results.size() == 0)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: result beat with nothing pending: %p", $realtime, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display({"%0t: mismatch solid/unsup/done/solid_total/unsup_total/free ",
                                  "exp %0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d"},
                                 $realtime, want.solid, want.unsup, want.done,
                                 want.solid_total, want.unsup_total, want.support_free,
                                 got.solid, got.unsup, got.done,
                                 got.solid_total, got.unsup_total, got.support_free);
                end
            end
        end
    end

    // Watchdog: end the run if no beat or register write moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule
